// ----- hdl/rto_pkg.sv -----
// shared types and constants of the retransmission timeout estimator
`timescale 1ns / 1ps
`default_nettype none

package rto_pkg;

  localparam int SEQ_W     = 32;
  localparam int TICK_W    = 32;
  localparam int MSS_W     = 16;
  localparam int GRAN_W    = MSS_W - 1;
  localparam int RETRY_W   = 8;
  localparam int OUT_TO_W  = 14;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;
  localparam int ACC_W     = 35;

  localparam logic [SEQ_W-1:0]   ISN_RESET     = '0;
  localparam logic [MSS_W-1:0]   MSS_RESET     = 16'd536;
  localparam logic [RETRY_W-1:0] RETRY_MAX     = 8'd255;
  localparam logic [RETRY_W-1:0] RESTART_AFTER = 8'd3;

  typedef enum logic [1:0] {
    CMD_SENT    = 2'd0,
    CMD_ACKED   = 2'd1,
    CMD_EXPIRED = 2'd2
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_SEQUENCE = 1'b0,
    REG_MIN_SEGMENT_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_EXEC,
    ST_DIFF,
    ST_VAR_A,
    ST_VAR_B,
    ST_SRTT_A,
    ST_SRTT_B,
    ST_RTO_A,
    ST_RTO_B,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [SEQ_W-1:0]  sequence_number;
    logic [TICK_W-1:0] now_ticks;
  } cmd_t;

  typedef struct packed {
    logic [OUT_TO_W-1:0] timeout_ticks;
    logic                sample_taken;
  } res_t;

  typedef struct packed {
    logic               used;
    logic [SEQ_W-1:0]   seq_num;
    logic [TICK_W-1:0]  start;
    logic [RETRY_W-1:0] retries;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/rto_div.sv -----
// serial hash unit: offset divided by granule, quotient reduced modulo table size
`timescale 1ns / 1ps
`default_nettype none

module rto_div #(
  parameter int MAP_ENTRIES = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [rto_pkg::SEQ_W-1:0]           dividend,
  input  wire logic [rto_pkg::GRAN_W-1:0]          divisor,
  output logic                                     done,
  output logic [$clog2(MAP_ENTRIES)-1:0]           index
);

  localparam int IDX_W = $clog2(MAP_ENTRIES);
  localparam int DVD_W = rto_pkg::SEQ_W;
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam int GW    = rto_pkg::GRAN_W;
  localparam logic [IDX_W:0]   MOD      = (IDX_W + 1)'(MAP_ENTRIES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DVD_W - 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DVD_W-1:0] dvd;
  logic [GW-1:0]    dvs;
  logic [GW-1:0]    rem;

  logic [GW:0]      trial;
  logic             ge;
  logic [GW-1:0]    rem_next;
  logic [IDX_W:0]   mod_trial;
  logic [IDX_W-1:0] index_next;

  always_comb begin
    trial    = {rem, dvd[DVD_W-1]};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? GW'(trial - {1'b0, dvs}) : trial[GW-1:0];
    mod_trial  = {index, ge};
    index_next = (mod_trial >= MOD) ? IDX_W'(mod_trial - MOD) : mod_trial[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == LAST_CNT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dvs   <= divisor;
      rem   <= '0;
      index <= '0;
    end else if (busy) begin
      dvd   <= {dvd[DVD_W-2:0], 1'b0};
      rem   <= rem_next;
      index <= index_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rto_table.sv -----
// segment table: used marks with clearing pass, and sequence, start and retry store
`timescale 1ns / 1ps
`default_nettype none

module rto_table #(
  parameter int MAP_ENTRIES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(MAP_ENTRIES)-1:0] rd_addr,
  output rto_pkg::entry_t                    rd_entry,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(MAP_ENTRIES)-1:0] wr_addr,
  input  wire rto_pkg::entry_t               wr_entry,
  output logic                               clearing
);

  localparam int IDX_W = $clog2(MAP_ENTRIES);
  localparam int DAT_W = rto_pkg::SEQ_W + rto_pkg::TICK_W + rto_pkg::RETRY_W;
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAP_ENTRIES - 1);

  logic             used_mem [MAP_ENTRIES];
  logic [DAT_W-1:0] data_mem [MAP_ENTRIES];
  logic [IDX_W-1:0] clr_addr;
  logic             rd_used;
  logic [DAT_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      used_mem[clr_addr] <= 1'b0;
    end else if (wr_en) begin
      used_mem[wr_addr] <= wr_entry.used;
    end
    if (rd_en) begin
      rd_used <= used_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      data_mem[wr_addr] <= {wr_entry.seq_num, wr_entry.start, wr_entry.retries};
    end
    if (rd_en) begin
      rd_data <= data_mem[rd_addr];
    end
  end

  always_comb begin
    rd_entry.used    = rd_used;
    rd_entry.seq_num = rd_data[DAT_W-1 -: rto_pkg::SEQ_W];
    rd_entry.start   = rd_data[rto_pkg::RETRY_W +: rto_pkg::TICK_W];
    rd_entry.retries = rd_data[rto_pkg::RETRY_W-1:0];
  end

endmodule

`default_nettype wire

// ----- hdl/tcp_retransmission_timeout_estimator.sv -----
// top level: sequencer, rtt estimator datapath and request/result registers
// a request passes the 32-step serial hash, table read, execute and, for a sample, the update states
// one request in flight; a new request is taken once the previous result is loaded and the state is idle
// after reset all MAP_ENTRIES used marks are swept clear before the first request is taken
// reset: rto 3 s of ticks, srtt and rttvar zero, next sample treated as first
`timescale 1ns / 1ps
`default_nettype none

module tcp_retransmission_timeout_estimator #(
  parameter int MAP_ENTRIES      = 64,
  parameter int TICKS_PER_SECOND = 100
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cmd_valid,
  output logic                                   cmd_stall,
  input  wire rto_pkg::cmd_t                     cmd,
  output logic                                   res_valid,
  input  wire logic                              res_stall,
  output rto_pkg::res_t                          res,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rto_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rto_pkg::CFG_W-1:0]         cfg_data
);

  localparam int IDX_W = $clog2(MAP_ENTRIES);
  localparam int RTO_MAX_VAL = 120 * TICKS_PER_SECOND;
  localparam int TO_W  = $clog2(RTO_MAX_VAL + 1);
  localparam int EXT_W = (TO_W > rto_pkg::OUT_TO_W) ? TO_W : rto_pkg::OUT_TO_W;
  localparam int AW    = rto_pkg::ACC_W;
  localparam int SW    = rto_pkg::SEQ_W;
  localparam int TW    = rto_pkg::TICK_W;
  localparam int RW    = rto_pkg::RETRY_W;

  localparam logic [TO_W-1:0] RTO_INITIAL = TO_W'(3 * TICKS_PER_SECOND);
  localparam logic [TO_W-1:0] RTO_MIN     = TO_W'(1 * TICKS_PER_SECOND);
  localparam logic [TO_W-1:0] RTO_MAX     = TO_W'(RTO_MAX_VAL);

  rto_pkg::state_t state;
  rto_pkg::state_t state_next;

  logic [SW-1:0]            initial_sequence;
  logic [rto_pkg::MSS_W-1:0] min_segment_size;

  rto_pkg::cmd_t   cmd_q;
  logic [IDX_W-1:0] slot;
  logic [TW-1:0]   smoothed_rtt;
  logic [TW-1:0]   rtt_variance;
  logic [TO_W-1:0] current_timeout;
  logic            first_sample;
  logic            sampled;
  logic [TW-1:0]   rtt;
  logic [TW-1:0]   diff;
  logic [AW-1:0]   acc;

  logic                      cmd_accept;
  logic [SW-1:0]             offset;
  logic [rto_pkg::GRAN_W-1:0] granule;
  logic [rto_pkg::GRAN_W-1:0] divisor;
  logic                      div_done;
  logic [IDX_W-1:0]          div_index;
  logic                      clearing;

  logic            rd_en;
  logic            wr_en;
  rto_pkg::entry_t entry;
  rto_pkg::entry_t wr_entry;

  logic            match;
  logic [RW-1:0]   retries_inc;
  logic [TO_W:0]   doubled;
  logic [TO_W-1:0] timeout_dbl;
  logic [TW-1:0]   rtt_now;
  logic [AW-1:0]   spread;
  logic [TO_W-1:0] rto_clamped;
  logic [EXT_W-1:0] timeout_ext;
  logic            res_load;

  assign cfg_ready  = 1'b1;
  assign cmd_stall  = (state != rto_pkg::ST_IDLE) || clearing;
  assign cmd_accept = cmd_valid && !cmd_stall;

  always_comb begin
    offset  = cmd.sequence_number - initial_sequence;
    granule = min_segment_size[rto_pkg::MSS_W-1:1];
    divisor = (granule == '0) ? rto_pkg::GRAN_W'(1) : granule;
  end

  rto_div #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd_accept),
    .dividend (offset),
    .divisor  (divisor),
    .done     (div_done),
    .index    (div_index)
  );

  rto_table #(
    .MAP_ENTRIES(MAP_ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr  (slot),
    .rd_entry (entry),
    .wr_en    (wr_en),
    .wr_addr  (slot),
    .wr_entry (wr_entry),
    .clearing (clearing)
  );

  // entry decode and timeout arithmetic
  always_comb begin
    match       = entry.used && (entry.seq_num == cmd_q.sequence_number);
    retries_inc = (entry.retries == rto_pkg::RETRY_MAX) ? entry.retries : entry.retries + 1'b1;
    doubled     = {current_timeout, 1'b0};
    timeout_dbl = (doubled > {1'b0, RTO_MAX}) ? RTO_MAX : doubled[TO_W-1:0];
    rtt_now     = cmd_q.now_ticks - entry.start;
    spread      = (rtt_variance == '0) ? AW'(1) : AW'({rtt_variance, 2'b00});
    if (acc < AW'(RTO_MIN)) begin
      rto_clamped = RTO_MIN;
    end else if (acc > AW'(RTO_MAX)) begin
      rto_clamped = RTO_MAX;
    end else begin
      rto_clamped = acc[TO_W-1:0];
    end
    timeout_ext = EXT_W'(current_timeout);
  end

  // sequencer
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_entry   = entry;
    res_load   = 1'b0;
    unique case (state)
      rto_pkg::ST_IDLE: begin
        if (cmd_accept) begin
          state_next = rto_pkg::ST_HASH;
        end
      end
      rto_pkg::ST_HASH: begin
        if (div_done) begin
          state_next = rto_pkg::ST_READ;
        end
      end
      rto_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = rto_pkg::ST_EXEC;
      end
      rto_pkg::ST_EXEC: begin
        state_next = rto_pkg::ST_FINISH;
        unique case (cmd_q.command)
          rto_pkg::CMD_SENT: begin
            wr_en = 1'b1;
            if (match) begin
              wr_entry.retries = retries_inc;
            end else begin
              wr_entry.used    = 1'b1;
              wr_entry.seq_num = cmd_q.sequence_number;
              wr_entry.start   = cmd_q.now_ticks;
              wr_entry.retries = '0;
            end
          end
          rto_pkg::CMD_ACKED: begin
            if (match && entry.retries == '0) begin
              state_next = first_sample ? rto_pkg::ST_RTO_A : rto_pkg::ST_DIFF;
            end
          end
          rto_pkg::CMD_EXPIRED: begin
            if (match) begin
              wr_en            = 1'b1;
              wr_entry.retries = retries_inc;
            end
          end
          default: begin
          end
        endcase
      end
      rto_pkg::ST_DIFF:   state_next = rto_pkg::ST_VAR_A;
      rto_pkg::ST_VAR_A:  state_next = rto_pkg::ST_VAR_B;
      rto_pkg::ST_VAR_B:  state_next = rto_pkg::ST_SRTT_A;
      rto_pkg::ST_SRTT_A: state_next = rto_pkg::ST_SRTT_B;
      rto_pkg::ST_SRTT_B: state_next = rto_pkg::ST_RTO_A;
      rto_pkg::ST_RTO_A:  state_next = rto_pkg::ST_RTO_B;
      rto_pkg::ST_RTO_B:  state_next = rto_pkg::ST_FINISH;
      rto_pkg::ST_FINISH: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = rto_pkg::ST_IDLE;
        end
      end
      default: state_next = rto_pkg::ST_IDLE;
    endcase
  end

  // control and estimator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= rto_pkg::ST_IDLE;
      res_valid        <= 1'b0;
      initial_sequence <= rto_pkg::ISN_RESET;
      min_segment_size <= rto_pkg::MSS_RESET;
      smoothed_rtt     <= '0;
      rtt_variance     <= '0;
      current_timeout  <= RTO_INITIAL;
      first_sample     <= 1'b1;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (rto_pkg::cfg_reg_t'(cfg_index))
          rto_pkg::REG_INITIAL_SEQUENCE: initial_sequence <= cfg_data;
          rto_pkg::REG_MIN_SEGMENT_SIZE: min_segment_size <= cfg_data[rto_pkg::MSS_W-1:0];
        endcase
      end
      unique case (state)
        rto_pkg::ST_EXEC: begin
          unique case (cmd_q.command)
            rto_pkg::CMD_ACKED: begin
              if (match && entry.retries == '0 && first_sample) begin
                first_sample <= 1'b0;
                smoothed_rtt <= rtt_now;
                rtt_variance <= {1'b0, rtt_now[TW-1:1]};
              end
            end
            rto_pkg::CMD_EXPIRED: begin
              current_timeout <= timeout_dbl;
              if (match && retries_inc >= rto_pkg::RESTART_AFTER) begin
                first_sample <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        rto_pkg::ST_VAR_B:  rtt_variance <= TW'((acc + AW'(diff)) >> 2);
        rto_pkg::ST_SRTT_B: smoothed_rtt <= TW'((acc + AW'(rtt)) >> 3);
        rto_pkg::ST_RTO_B:  current_timeout <= rto_clamped;
        default: begin
        end
      endcase
    end
  end

  // request and working registers
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      cmd_q   <= cmd;
      sampled <= 1'b0;
    end
    if (state == rto_pkg::ST_HASH && div_done) begin
      slot <= div_index;
    end
    unique case (state)
      rto_pkg::ST_EXEC: begin
        if (cmd_q.command == rto_pkg::CMD_ACKED && match && entry.retries == '0) begin
          sampled <= 1'b1;
          rtt     <= rtt_now;
        end
      end
      rto_pkg::ST_DIFF: begin
        diff <= (smoothed_rtt >= rtt) ? smoothed_rtt - rtt : rtt - smoothed_rtt;
      end
      rto_pkg::ST_VAR_A: acc <= AW'({rtt_variance, 1'b0}) + AW'(rtt_variance);
      rto_pkg::ST_SRTT_A: acc <= AW'({smoothed_rtt, 3'b000}) - AW'(smoothed_rtt);
      rto_pkg::ST_RTO_A: acc <= AW'(smoothed_rtt) + spread;
      default: begin
      end
    endcase
    if (res_load) begin
      res <= '{timeout_ticks: timeout_ext[rto_pkg::OUT_TO_W-1:0],
               sample_taken:  sampled};
    end
  end

endmodule

`default_nettype wire
